/* rtl/ctld_pkg.sv */
// ---------------------------------------------------------------------------
// ctld_pkg
// shared types and constants of the chunked transfer line deframer
// ---------------------------------------------------------------------------
package ctld_pkg;

    // result kinds
    localparam logic [2:0] K_PAYLOAD  = 3'd0;
    localparam logic [2:0] K_LINE_END = 3'd1;
    localparam logic [2:0] K_BLANK    = 3'd2;
    localparam logic [2:0] K_DISCARD  = 3'd3;
    localparam logic [2:0] K_ENDED    = 3'd4;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [15:0] MAX_LINE_RESET = 16'd767;

    // command queue between the framing front and the line back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
    } t_cmd;

endpackage

/* rtl/ctld_front.sv */
// ---------------------------------------------------------------------------
// ctld_front
// chunk framing parser: size line, chunk data count and chunk trailer
// ---------------------------------------------------------------------------
module ctld_front #(
    parameter int SIZE_BITS  = 32,
    parameter int SIZE_CHARS = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_q_full,
    output logic          o_stall,
    output logic          o_push,
    output ctld_pkg::t_cmd o_push_cmd
);

    localparam logic [1:0] PH_SIZE  = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_CRLF  = 2'd2;
    localparam logic [1:0] PH_ENDED = 2'd3;

    logic [1:0]           r_phase,      n_phase;
    logic [SIZE_BITS-1:0] r_size_value, n_size_value;
    logic [3:0]           r_size_cnt,   n_size_cnt;
    logic                 r_size_stop,  n_size_stop;
    logic [SIZE_BITS-1:0] r_bytes_left, n_bytes_left;
    logic                 accept;
    logic [4:0]           hex;
    logic                 sat;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign hex     = hex_digit(i_byte);
    // value times 16 would pass the top
    assign sat     = |r_size_value[SIZE_BITS-1:SIZE_BITS-4];

    always_comb begin
        n_phase      = r_phase;
        n_size_value = r_size_value;
        n_size_cnt   = r_size_cnt;
        n_size_stop  = r_size_stop;
        n_bytes_left = r_bytes_left;
        o_push       = 1'b0;
        o_push_cmd   = '0;
        if (accept) begin
            unique case (r_phase)
                PH_SIZE: begin
                    if (i_byte == ctld_pkg::CH_CR) begin
                        n_phase = r_phase;
                    end else if (i_byte == ctld_pkg::CH_LF) begin
                        if (r_size_value == '0) begin
                            n_phase           = PH_ENDED;
                            o_push            = 1'b1;
                            o_push_cmd.is_end = 1'b1;
                        end else begin
                            n_bytes_left = r_size_value;
                            n_phase      = PH_DATA;
                        end
                        n_size_value = '0;
                        n_size_cnt   = '0;
                        n_size_stop  = 1'b0;
                    end else if (r_size_cnt < 4'(SIZE_CHARS)) begin
                        n_size_cnt = r_size_cnt + 4'd1;
                        if (!r_size_stop) begin
                            if (hex[4]) begin
                                n_size_value = sat ? '1 :
                                    {r_size_value[SIZE_BITS-5:0], hex[3:0]};
                            end else begin
                                n_size_stop = 1'b1;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    o_push          = 1'b1;
                    o_push_cmd.data = i_byte;
                    if (r_bytes_left != '0) begin
                        n_bytes_left = r_bytes_left - 1'b1;
                    end
                    if (r_bytes_left <= SIZE_BITS'(1)) begin
                        n_phase = PH_CRLF;
                    end
                end
                PH_CRLF: begin
                    if (i_byte == ctld_pkg::CH_LF) begin
                        n_phase = PH_SIZE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIZE;
            r_size_value <= '0;
            r_size_cnt   <= '0;
            r_size_stop  <= 1'b0;
            r_bytes_left <= '0;
        end else begin
            r_phase      <= n_phase;
            r_size_value <= n_size_value;
            r_size_cnt   <= n_size_cnt;
            r_size_stop  <= n_size_stop;
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

/* rtl/ctld_queue.sv */
// ---------------------------------------------------------------------------
// ctld_queue
// short command fifo between the framing front and the line back
// ---------------------------------------------------------------------------
module ctld_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ctld_pkg::t_cmd i_push_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output ctld_pkg::t_cmd o_cmd
);

    ctld_pkg::t_cmd                 r_mem [ctld_pkg::Q_DEPTH];
    logic [ctld_pkg::Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [ctld_pkg::Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [ctld_pkg::Q_CNT_W-1:0]   r_count,  n_count;
    logic                           do_pop;

    assign o_full  = (r_count == ctld_pkg::Q_CNT_W'(ctld_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || do_pop)
        else $error("push into full command queue");

endmodule

/* rtl/ctld_back.sv */
// ---------------------------------------------------------------------------
// ctld_back
// line splitter: held cr, line length limit and result sequencing
// ---------------------------------------------------------------------------
module ctld_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [15:0]    i_cfg_wr_data,
    input  logic           i_q_valid,
    input  ctld_pkg::t_cmd i_q_cmd,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_data_byte,
    output logic [2:0]     o_kind,
    output logic           o_last
);

    logic [15:0] r_max_line;
    logic [15:0] r_line_len, n_line_len;
    logic        r_cr_pend,  n_cr_pend;

    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic [2:0]  r_out_kind;
    logic        r_out_last;
    logic        r_sec_valid;
    logic [7:0]  r_sec_data;
    logic [2:0]  r_sec_kind;

    logic        slot_free;
    logic [1:0]  res_n;
    logic [7:0]  res0_data, res1_data;
    logic [2:0]  res0_kind;
    logic [7:0]  c;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_pop     = i_q_valid && !r_sec_valid && slot_free;
    assign c         = i_q_cmd.data;

    always_comb begin
        n_line_len = r_line_len;
        n_cr_pend  = r_cr_pend;
        res_n      = 2'd0;
        res0_data  = 8'd0;
        res0_kind  = ctld_pkg::K_PAYLOAD;
        res1_data  = 8'd0;
        if (i_q_cmd.is_end) begin
            res_n     = 2'd1;
            res0_kind = ctld_pkg::K_ENDED;
        end else if (c == ctld_pkg::CH_LF) begin
            res_n = 2'd1;
            // a held cr does not count toward a non-blank line
            if (r_line_len > 16'd1 || (r_line_len == 16'd1 && !r_cr_pend)) begin
                res0_kind = ctld_pkg::K_LINE_END;
            end else begin
                res0_kind = ctld_pkg::K_BLANK;
            end
            n_line_len = '0;
            n_cr_pend  = 1'b0;
        end else if (r_line_len < r_max_line) begin
            n_cr_pend  = (c == ctld_pkg::CH_CR);
            n_line_len = r_line_len + 16'd1;
            if (r_cr_pend) begin
                res0_data = ctld_pkg::CH_CR;
                res1_data = c;
                res_n     = (c == ctld_pkg::CH_CR) ? 2'd1 : 2'd2;
            end else begin
                res0_data = c;
                res_n     = (c == ctld_pkg::CH_CR) ? 2'd0 : 2'd1;
            end
        end else begin
            res_n      = 2'd1;
            res0_kind  = ctld_pkg::K_DISCARD;
            n_line_len = '0;
            n_cr_pend  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line <= ctld_pkg::MAX_LINE_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_line <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= '0;
            r_cr_pend  <= 1'b0;
        end else if (o_pop) begin
            r_line_len <= n_line_len;
            r_cr_pend  <= n_cr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sec_valid <= 1'b0;
        end else if (slot_free) begin
            if (r_sec_valid) begin
                r_out_valid <= 1'b1;
                r_sec_valid <= 1'b0;
            end else if (o_pop && res_n != 2'd0) begin
                r_out_valid <= 1'b1;
                r_sec_valid <= (res_n == 2'd2);
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            if (r_sec_valid) begin
                r_out_data <= r_sec_data;
                r_out_kind <= r_sec_kind;
                r_out_last <= 1'b1;
            end else if (o_pop) begin
                r_out_data <= res0_data;
                r_out_kind <= res0_kind;
                r_out_last <= (res_n == 2'd1);
                r_sec_data <= res1_data;
                r_sec_kind <= ctld_pkg::K_PAYLOAD;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_out_data;
    assign o_kind      = r_out_kind;
    assign o_last      = r_out_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec_valid |-> r_out_valid && !r_out_last)
        else $error("second result held without a first one in front");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_sec_valid)
        else $error("request taken while a second result is pending");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind != ctld_pkg::K_PAYLOAD |-> r_out_data == 8'd0 && r_out_last)
        else $error("marker result carries data or is not last");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_kind))
        else $error("stalled result changed");

endmodule

/* rtl/chunked_transfer_line_deframer.sv */
// ---------------------------------------------------------------------------
// chunked_transfer_line_deframer
// removes chunk framing from a chunked body and splits payload into lines
// ---------------------------------------------------------------------------
// a result passes the command queue and then the output register of the line back
// throughput: one byte per cycle while the command queue is not full; a byte that releases a
//   held cr gives two results, the second waits in a holding register of the line back
// the four-entry command queue absorbs the held-back second results and output stalls
// reset is synchronous: all framing and line state clears, max_line_bytes
//   returns to 767
module chunked_transfer_line_deframer #(
    parameter int SIZE_BITS  = 32,
    parameter int SIZE_CHARS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_kind,
    output logic        o_last
);

    logic           q_full;
    logic           q_push;
    ctld_pkg::t_cmd q_push_cmd;
    logic           q_pop;
    logic           q_valid;
    ctld_pkg::t_cmd q_cmd;

    ctld_front #(
        .SIZE_BITS  (SIZE_BITS),
        .SIZE_CHARS (SIZE_CHARS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_byte     (i_byte_in),
        .i_q_full   (q_full),
        .o_stall    (o_in_stall),
        .o_push     (q_push),
        .o_push_cmd (q_push_cmd)
    );

    ctld_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd)
    );

    ctld_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_data_byte   (o_data_byte),
        .o_kind        (o_kind),
        .o_last        (o_last)
    );

endmodule

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// tb
// checks the chunked transfer line deframer against a cycle-free predictor:
// chunk-framed byte streams go in with random sender gaps and receiver stalls,
// every result is compared field by field in order, across several line limits
// ---------------------------------------------------------------------------
module tb;

    typedef enum logic [1:0] {PH_SIZE, PH_DATA, PH_CRLF, PH_ENDED} t_frame_phase;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic       last;
    } t_result;

    localparam int SIZE_CHARS    = 15;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_BYTES   = 60;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = 16'd0;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_byte_in     = 8'd0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_data_byte;
    logic [2:0]  o_kind;
    logic        o_last;

    chunked_transfer_line_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_byte_in     (i_byte_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_data_byte   (o_data_byte),
        .o_kind        (o_kind),
        .o_last        (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    t_frame_phase fr_phase   = PH_SIZE;
    logic [31:0]  size_acc   = '0;
    logic [3:0]   size_cnt   = '0;
    bit           size_stop  = 1'b0;
    logic [31:0]  chunk_left = '0;
    logic [15:0]  line_len   = '0;
    bit           cr_held    = 1'b0;
    logic [15:0]  line_limit = ctld_pkg::MAX_LINE_RESET;

    t_result    due_results[$];
    logic [7:0] tx_bytes[$];
    int         errors  = 0;
    bit         idle_on = 1'b1;

    function automatic void deframe_byte(input logic [7:0] c);
        t_result     r [2];
        int          n = 0;
        int          d = -1;
        logic [15:0] len;
        case (fr_phase)
            PH_SIZE: begin
                if (c == ctld_pkg::CH_LF) begin
                    if (size_acc == 0) begin
                        fr_phase = PH_ENDED;
                        r[n] = '{8'h00, ctld_pkg::K_ENDED, 1'b0};
                        n++;
                    end else begin
                        chunk_left = size_acc;
                        fr_phase   = PH_DATA;
                    end
                    size_acc  = '0;
                    size_cnt  = '0;
                    size_stop = 1'b0;
                end else if (c != ctld_pkg::CH_CR && size_cnt < SIZE_CHARS) begin
                    size_cnt++;
                    if (c >= "0" && c <= "9") d = c - "0";
                    else if (c >= "a" && c <= "f") d = c - "a" + 10;
                    else if (c >= "A" && c <= "F") d = c - "A" + 10;
                    if (!size_stop) begin
                        if (d < 0) size_stop = 1'b1;
                        else if (size_acc > 32'h0FFF_FFFF) size_acc = '1;
                        else size_acc = {size_acc[27:0], d[3:0]};
                    end
                end
            end
            PH_DATA: begin
                if (c == ctld_pkg::CH_LF) begin
                    // a held cr belongs to the line end, not to the line
                    len = line_len;
                    if (cr_held && len != 0) len--;
                    r[n] = '{8'h00, (len != 0) ? ctld_pkg::K_LINE_END : ctld_pkg::K_BLANK,
                             1'b0};
                    n++;
                    line_len = '0;
                    cr_held  = 1'b0;
                end else if (line_len < line_limit) begin
                    if (cr_held) begin
                        r[n] = '{ctld_pkg::CH_CR, ctld_pkg::K_PAYLOAD, 1'b0};
                        n++;
                    end
                    cr_held = (c == ctld_pkg::CH_CR);
                    if (!cr_held) begin
                        r[n] = '{c, ctld_pkg::K_PAYLOAD, 1'b0};
                        n++;
                    end
                    line_len++;
                end else begin
                    line_len = '0;
                    cr_held  = 1'b0;
                    r[n] = '{8'h00, ctld_pkg::K_DISCARD, 1'b0};
                    n++;
                end
                if (chunk_left != 0) chunk_left--;
                if (chunk_left == 0) fr_phase = PH_CRLF;
            end
            PH_CRLF: begin
                if (c == ctld_pkg::CH_LF) fr_phase = PH_SIZE;
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) r[i].last = 1'b1;
            due_results.push_back(r[i]);
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10) return "0" + v;
        return 8'((($urandom_range(0, 1) != 0) ? "a" : "A") + v - 10);
    endfunction

    function automatic logic [7:0] payload_char(input bit allow_lf);
        int         r = $urandom_range(0, 99);
        logic [7:0] c;
        if (r < 10) c = ctld_pkg::CH_LF;
        else if (r < 22) c = ctld_pkg::CH_CR;
        else if (r < 40) c = 8'($urandom_range(0, 255));
        else c = 8'($urandom_range(32, 126));
        if (!allow_lf && c == ctld_pkg::CH_LF) c = ctld_pkg::CH_CR;
        return c;
    endfunction

    // one chunk: size line with optional padding, stray cr and extension,
    // then exactly len payload bytes, then the closing crlf with optional junk
    function automatic void add_chunk(input int unsigned len, input bit allow_lf);
        int         nd = 0;
        int         zeros;
        bit         over_long;
        logic [7:0] c;
        for (int unsigned v = len; v != 0; v >>= 4) nd++;
        // over-long lines fill the kept characters exactly, the rest is dropped
        over_long = ($urandom_range(0, 9) == 0);
        zeros = over_long ? SIZE_CHARS - nd : $urandom_range(0, 2);
        for (int i = 0; i < zeros; i++) tx_bytes.push_back("0");
        for (int i = nd - 1; i >= 0; i--) begin
            if ($urandom_range(0, 9) == 0) tx_bytes.push_back(ctld_pkg::CH_CR);
            tx_bytes.push_back(hex_char(4'((len >> (4 * i)) & 15)));
        end
        if (over_long) begin
            repeat ($urandom_range(1, 3))
                tx_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0: c = ";";
                1: c = " ";
                2: c = "-";
                default: c = "g";
            endcase
            tx_bytes.push_back(c);
            repeat ($urandom_range(0, 4)) tx_bytes.push_back(8'($urandom_range(33, 126)));
        end
        if ($urandom_range(0, 9) != 0) tx_bytes.push_back(ctld_pkg::CH_CR);
        tx_bytes.push_back(ctld_pkg::CH_LF);
        repeat (len) tx_bytes.push_back(payload_char(allow_lf));
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                c = 8'($urandom_range(0, 255));
                if (c == ctld_pkg::CH_LF) c = 8'h00;
                tx_bytes.push_back(c);
            end
        end
        if ($urandom_range(0, 9) != 0) tx_bytes.push_back(ctld_pkg::CH_CR);
        tx_bytes.push_back(ctld_pkg::CH_LF);
    endfunction

    function automatic void fill_phase(input int budget);
        int          queued = 0;
        int unsigned len;
        while (queued < budget) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
            add_chunk(len, 1'b1);
            queued += len + 6;
        end
    endfunction

    task automatic wait_idle();
        while (tx_bytes.size() != 0 || i_in_valid || due_results.size() != 0)
            @(negedge i_clk);
        // size line bytes give no result but may still be inside the block
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_line_limit(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        line_limit = v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // request side
    int gap_left = 0;
    always @(posedge i_clk) begin : drive_bytes
        bit hold;
        hold = i_in_valid && o_in_stall;
        if (i_in_valid && !o_in_stall) deframe_byte(i_byte_in);
        if (!hold) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (tx_bytes.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 7);
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_byte_in  <= tx_bytes.pop_front();
            end
        end
    end

    // result side
    int stall_left = 0;
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: data %02h kind %0d last %0b",
                             o_data_byte, o_kind, o_last);
            end else begin
                want = due_results.pop_front();
                if (o_data_byte !== want.data || o_kind !== want.kind ||
                    o_last !== want.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected data %02h kind %0d last %0b, ",
                                  "got data %02h kind %0d last %0b"},
                                 want.data, want.kind, want.last,
                                 o_data_byte, o_kind, o_last);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin : run_stimulus
        // size a with extension, blank line, cr inside a line, bare lf,
        // byte extremes, cr held across the chunk end, junk before the crlf
        logic [7:0]  opening [19] = '{ctld_pkg::CH_CR, "A", ";", "x", ctld_pkg::CH_CR,
                                      ctld_pkg::CH_LF, ctld_pkg::CH_CR, ctld_pkg::CH_LF,
                                      "x", ctld_pkg::CH_CR, ctld_pkg::CH_CR,
                                      ctld_pkg::CH_LF, ctld_pkg::CH_LF,
                                      8'hFF, 8'h00, ctld_pkg::CH_CR,
                                      "z", ctld_pkg::CH_CR, ctld_pkg::CH_LF};
        logic [15:0] limits [6];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (opening[i]) tx_bytes.push_back(opening[i]);
        fill_phase(PHASE_BYTES);

        limits = '{16'd1, 16'hFFFF, 16'd0, 16'd5, 16'($urandom_range(2, 12)),
                   16'($urandom_range(1, 30))};
        foreach (limits[p]) begin
            wait_idle();
            set_line_limit(limits[p]);
            idle_on = (p == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
            fill_phase(PHASE_BYTES);
        end

        if ($urandom_range(0, 1) != 0) begin
            // zero size ends the stream, everything after it is ignored
            tx_bytes.push_back("0");
            if ($urandom_range(0, 1) != 0) begin
                tx_bytes.push_back(";");
                tx_bytes.push_back("e");
            end
            tx_bytes.push_back(ctld_pkg::CH_CR);
            tx_bytes.push_back(ctld_pkg::CH_LF);
            repeat (8) tx_bytes.push_back(8'($urandom_range(0, 255)));
            tx_bytes.push_back(ctld_pkg::CH_LF);
        end else begin
            // size saturates, so the chunk outlasts the run
            repeat (10) tx_bytes.push_back(hex_char(4'hF));
            tx_bytes.push_back(ctld_pkg::CH_CR);
            tx_bytes.push_back(ctld_pkg::CH_LF);
            repeat (30) tx_bytes.push_back(payload_char(1'b1));
        end
        wait_idle();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #(20 * 600_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
